### sv/sfr_pkg.sv
// shared types and constants of the serial frame receiver
// no dependencies; used by sfr_frame_parse and serial_frame_receiver
package sfr_pkg;

   localparam int MAX_FRAME_DEF = 32;
   localparam int MIN_FRAME     = 3;
   localparam int BYTE_W        = 8;
   localparam int LEN_CFG_W     = 6;
   localparam int OUT_INDEX_W   = 5;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_A = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_B = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LEN = 2'd3;

   localparam logic [BYTE_W-1:0]    HEADER_RESET    = 8'd165;
   localparam logic [BYTE_W-1:0]    ADDRESS_RESET   = 8'd1;
   localparam logic [LEN_CFG_W-1:0] FRAME_LEN_RESET = 6'd13;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // frame events from the parser to the burst sequencer
   typedef struct packed {
      logic good;    // checksum matched, emit whole frame
      logic bad;     // checksum mismatch, emit one error transaction
      logic at_end;  // next byte completes the frame
   } frame_event_type;

endpackage

### sv/sfr_frame_parse.sv
// byte position, running checksum and header/address check of the receiver
// depends on sfr_pkg
module sfr_frame_parse #(
   parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF,
   parameter int IDX_W     = $clog2(MAX_FRAME),
   parameter int CMP_W     = IDX_W + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [sfr_pkg::BYTE_W-1:0]     rx_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]     header_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]     address_a,
   input  logic [sfr_pkg::BYTE_W-1:0]     address_b,
   input  logic [sfr_pkg::LEN_CFG_W-1:0]  frame_length,
   output logic [IDX_W-1:0]               position,
   output sfr_pkg::frame_event_type       frame_event
);

   logic [IDX_W-1:0]           pos_ff, pos_in;
   logic [sfr_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [sfr_pkg::BYTE_W-1:0] byte0_ff, byte0_in;
   logic [sfr_pkg::BYTE_W-1:0] byte1_ff, byte1_in;
   logic [CMP_W-1:0]           len;
   logic [CMP_W-1:0]           pos_next;
   logic [sfr_pkg::BYTE_W-1:0] b1;
   logic                       addr_ok;

   always_comb begin
      if (frame_length < sfr_pkg::LEN_CFG_W'(sfr_pkg::MIN_FRAME)) begin
         len = CMP_W'(sfr_pkg::MIN_FRAME);
      end else if (int'(frame_length) > MAX_FRAME) begin
         len = CMP_W'(MAX_FRAME);
      end else begin
         len = CMP_W'(frame_length);
      end
   end

   assign pos_next = CMP_W'(pos_ff) + CMP_W'(1);
   assign b1       = (pos_ff == IDX_W'(1)) ? rx_byte : byte1_ff;
   assign addr_ok  = (byte0_ff == header_byte) && ((b1 == address_a) || (b1 == address_b));

   always_comb begin
      pos_in             = pos_ff;
      sum_in             = sum_ff;
      byte0_in           = byte0_ff;
      byte1_in           = byte1_ff;
      frame_event.good   = 1'b0;
      frame_event.bad    = 1'b0;
      frame_event.at_end = (pos_next >= len);
      if (accept) begin
         if (pos_ff == '0) begin
            byte0_in = rx_byte;
            if (rx_byte == header_byte) begin
               pos_in = IDX_W'(1);
               sum_in = rx_byte;
            end
         end else begin
            if (pos_ff == IDX_W'(1)) begin
               byte1_in = rx_byte;
            end
            if (!addr_ok) begin
               pos_in = '0;
               sum_in = '0;
            end else if (pos_next < len) begin
               pos_in = pos_next[IDX_W-1:0];
               sum_in = sum_ff + rx_byte;
            end else begin
               // checksum byte: sum of all earlier bytes mod 256
               frame_event.good = (sum_ff == rx_byte);
               frame_event.bad  = (sum_ff != rx_byte);
               pos_in = '0;
               sum_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
   end

   assign position = pos_ff;

endmodule

### sv/serial_frame_receiver.sv
// serial frame receiver top level: config registers, frame store, burst output
// depends on sfr_pkg and sfr_frame_parse
//
// req channel: one received byte per transaction (req_rx_byte). rsp channel:
// one transaction per frame byte for a frame whose checksum matched, the
// last one flagged by rsp_last; a checksum mismatch gives a single
// transaction with rsp_status set. Bytes that break the header or address
// check are dropped and the frame restarts.
// Bytes are taken one per cycle while req_stall is low. The frame store has two
// banks: a finished frame drains from one bank while the next frame fills the
// other, so input and output overlap. Once the checksum byte is accepted, the
// burst state is registered and then the first result is loaded into the output
// register; the burst then gives one result per cycle while rsp_stall is low.
// req_stall rises only when the next byte would end a frame while the
// previous burst is still draining; it stays high until that burst is done.
// rsp_stall holds the output register and the burst position; nothing lost.
// csr_* writes may be issued only while the block is idle.
// Reset clears position, checksum, bank and burst state and loads the
// register defaults (header 165, both addresses 1, frame length 13).
module serial_frame_receiver #(
   parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_status,
   output logic [sfr_pkg::BYTE_W-1:0]       rsp_frame_byte,
   output logic [sfr_pkg::OUT_INDEX_W-1:0]  rsp_byte_index,
   output logic                             rsp_last,
   input  logic                             csr_wen,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfr_pkg::BYTE_W-1:0]       csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_FRAME);
   localparam int CMP_W  = IDX_W + 1;
   localparam int ADDR_W = IDX_W + 1;
   localparam int DEPTH  = 2 * MAX_FRAME;

   logic [sfr_pkg::BYTE_W-1:0]    header_ff;
   logic [sfr_pkg::BYTE_W-1:0]    address_a_ff;
   logic [sfr_pkg::BYTE_W-1:0]    address_b_ff;
   logic [sfr_pkg::LEN_CFG_W-1:0] frame_len_ff;

   logic [sfr_pkg::BYTE_W-1:0] store_mem [DEPTH];

   logic                     fill_bank_ff;
   logic                     burst_active_ff;
   logic                     burst_err_ff;
   logic                     burst_bank_ff;
   logic [IDX_W-1:0]         burst_idx_ff;
   logic [CMP_W-1:0]         burst_cnt_ff;

   logic                              rsp_valid_ff;
   logic                              rsp_status_ff;
   logic [sfr_pkg::BYTE_W-1:0]        rsp_frame_byte_ff;
   logic [sfr_pkg::OUT_INDEX_W-1:0]   rsp_byte_index_ff;
   logic                              rsp_last_ff;

   logic                      req_accept;
   logic [IDX_W-1:0]          position;
   sfr_pkg::frame_event_type  frame_event;
   logic                      out_load;
   logic                      burst_end;
   logic [ADDR_W-1:0]         rd_addr;

   // a byte that could end a frame waits until the previous burst is out
   assign req_stall  = burst_active_ff && frame_event.at_end;
   assign req_accept = req_valid && !req_stall;

   sfr_frame_parse #(
      .MAX_FRAME (MAX_FRAME),
      .IDX_W     (IDX_W),
      .CMP_W     (CMP_W)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .rx_byte      (req_rx_byte),
      .header_byte  (header_ff),
      .address_a    (address_a_ff),
      .address_b    (address_b_ff),
      .frame_length (frame_len_ff),
      .position     (position),
      .frame_event  (frame_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= sfr_pkg::HEADER_RESET;
         address_a_ff <= sfr_pkg::ADDRESS_RESET;
         address_b_ff <= sfr_pkg::ADDRESS_RESET;
         frame_len_ff <= sfr_pkg::FRAME_LEN_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            sfr_pkg::CSR_HEADER:    header_ff    <= csr_wdata;
            sfr_pkg::CSR_ADDRESS_A: address_a_ff <= csr_wdata;
            sfr_pkg::CSR_ADDRESS_B: address_b_ff <= csr_wdata;
            sfr_pkg::CSR_FRAME_LEN: frame_len_ff <= csr_wdata[sfr_pkg::LEN_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_load  = burst_active_ff && (!rsp_valid_ff || !rsp_stall);
   assign burst_end = burst_err_ff || (CMP_W'(burst_idx_ff) + CMP_W'(1) == burst_cnt_ff);
   assign rd_addr   = {burst_bank_ff, burst_idx_ff};

   // frame store: write port from the input side, registered read for the burst
   always_ff @(posedge clock) begin
      if (req_accept) begin
         store_mem[{fill_bank_ff, position}] <= req_rx_byte;
      end
      if (out_load) begin
         rsp_frame_byte_ff <= burst_err_ff ? '0 : store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_bank_ff    <= 1'b0;
         burst_active_ff <= 1'b0;
         burst_err_ff    <= 1'b0;
         burst_bank_ff   <= 1'b0;
         burst_idx_ff    <= '0;
         burst_cnt_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (frame_event.good || frame_event.bad) begin
            // a new burst only starts once the previous one has drained
            burst_active_ff <= 1'b1;
            burst_err_ff    <= frame_event.bad;
            burst_bank_ff   <= fill_bank_ff;
            burst_idx_ff    <= '0;
            burst_cnt_ff    <= CMP_W'(position) + CMP_W'(1);
            if (frame_event.good) begin
               fill_bank_ff <= !fill_bank_ff;
            end
         end else if (out_load) begin
            burst_idx_ff <= burst_idx_ff + IDX_W'(1);
            if (burst_end) begin
               burst_active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff     <= burst_err_ff ? sfr_pkg::STATUS_ERR : sfr_pkg::STATUS_OK;
         rsp_byte_index_ff <= burst_err_ff ? '0 : sfr_pkg::OUT_INDEX_W'(burst_idx_ff);
         rsp_last_ff       <= burst_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_frame_byte = rsp_frame_byte_ff;
   assign rsp_byte_index = rsp_byte_index_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### sim/serial_frame_receiver_checker.sv
// result checker for the serial frame receiver: tracks header, address and checksum
// state from observed req and csr transactions and compares every rsp transaction
// depends on sfr_pkg for widths, register indexes and status codes
`timescale 1ns / 1ps

module serial_frame_receiver_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]          req_rx_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_status,
   input  logic [sfr_pkg::BYTE_W-1:0]          rsp_frame_byte,
   input  logic [sfr_pkg::OUT_INDEX_W-1:0]     rsp_byte_index,
   input  logic                                rsp_last,
   input  logic                                csr_wen,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sfr_pkg::BYTE_W-1:0]          csr_wdata,
   output int                                  fail_count,
   output int                                  results_pending
);

   localparam int FRAME_MAX = sfr_pkg::MAX_FRAME_DEF;

   typedef struct packed {
      logic                            status;
      logic [sfr_pkg::BYTE_W-1:0]      frame_byte;
      logic [sfr_pkg::OUT_INDEX_W-1:0] byte_index;
      logic                            last;
   } frame_result_type;

   logic [sfr_pkg::BYTE_W-1:0]    hdr_reg;
   logic [sfr_pkg::BYTE_W-1:0]    addr_a_reg;
   logic [sfr_pkg::BYTE_W-1:0]    addr_b_reg;
   logic [sfr_pkg::LEN_CFG_W-1:0] len_reg;

   logic [sfr_pkg::BYTE_W-1:0] held_bytes [0:FRAME_MAX-1];
   int                         held_count;
   logic [sfr_pkg::BYTE_W-1:0] held_sum;

   frame_result_type frame_results_due [$];
   frame_result_type due;
   int               mismatches;

   // one received byte: header and address checks, checksum at the frame end
   task automatic absorb_rx_byte(input logic [sfr_pkg::BYTE_W-1:0] rx);
      int               frame_len;
      int               pos;
      frame_result_type res;
      frame_len = len_reg;
      if (frame_len < sfr_pkg::MIN_FRAME) frame_len = sfr_pkg::MIN_FRAME;
      if (frame_len > FRAME_MAX) frame_len = FRAME_MAX;
      pos = held_count;
      if (pos >= FRAME_MAX) begin
         pos      = 0;
         held_sum = '0;
      end
      held_bytes[pos] = rx;
      pos++;
      if (pos == 1) begin
         if (rx != hdr_reg) begin
            held_count = 0;
            held_sum   = '0;
         end else begin
            held_count = 1;
            held_sum   = held_sum + rx;
         end
         return;
      end
      // stored header and address are rechecked on every later byte
      if (held_bytes[0] != hdr_reg ||
          (held_bytes[1] != addr_a_reg && held_bytes[1] != addr_b_reg)) begin
         held_count = 0;
         held_sum   = '0;
         return;
      end
      if (pos < frame_len) begin
         held_count = pos;
         held_sum   = held_sum + rx;
         return;
      end
      if (held_sum != rx) begin
         res.status     = sfr_pkg::STATUS_ERR;
         res.frame_byte = '0;
         res.byte_index = '0;
         res.last       = 1'b1;
         frame_results_due.push_back(res);
      end else begin
         for (int k = 0; k < pos; k++) begin
            res.status     = sfr_pkg::STATUS_OK;
            res.frame_byte = held_bytes[k];
            res.byte_index = k[sfr_pkg::OUT_INDEX_W-1:0];
            res.last       = (k + 1 == pos);
            frame_results_due.push_back(res);
         end
      end
      held_count = 0;
      held_sum   = '0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hdr_reg    = sfr_pkg::HEADER_RESET;
         addr_a_reg = sfr_pkg::ADDRESS_RESET;
         addr_b_reg = sfr_pkg::ADDRESS_RESET;
         len_reg    = sfr_pkg::FRAME_LEN_RESET;
         held_count = 0;
         held_sum   = '0;
         frame_results_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               sfr_pkg::CSR_HEADER:    hdr_reg    = csr_wdata;
               sfr_pkg::CSR_ADDRESS_A: addr_a_reg = csr_wdata;
               sfr_pkg::CSR_ADDRESS_B: addr_b_reg = csr_wdata;
               sfr_pkg::CSR_FRAME_LEN: len_reg    = csr_wdata[sfr_pkg::LEN_CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) absorb_rx_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (frame_results_due.size() == 0) begin
               $error("unexpected rsp transaction: status %0d frame_byte %0h index %0d",
                      rsp_status, rsp_frame_byte, rsp_byte_index);
               fail_count <= fail_count + 1;
            end else begin
               due        = frame_results_due.pop_front();
               mismatches = 0;
               if (rsp_status !== due.status) begin
                  $error("rsp_status: expected %0d, actual %0d", due.status, rsp_status);
                  mismatches++;
               end
               if (rsp_frame_byte !== due.frame_byte) begin
                  $error("rsp_frame_byte: expected %0h, actual %0h",
                         due.frame_byte, rsp_frame_byte);
                  mismatches++;
               end
               if (rsp_byte_index !== due.byte_index) begin
                  $error("rsp_byte_index: expected %0d, actual %0d",
                         due.byte_index, rsp_byte_index);
                  mismatches++;
               end
               if (rsp_last !== due.last) begin
                  $error("rsp_last: expected %0d, actual %0d", due.last, rsp_last);
                  mismatches++;
               end
               fail_count <= fail_count + mismatches;
            end
         end
      end
      results_pending <= frame_results_due.size();
   end

endmodule

### sim/serial_frame_receiver_tb.sv
// testbench top for the serial frame receiver: clock, reset, byte stimulus,
// register writes, output stalling and the final verdict
// depends on sfr_pkg, serial_frame_receiver and serial_frame_receiver_checker
`timescale 1ns / 1ps

module serial_frame_receiver_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_BYTES  = 40;
   localparam int HOLD_CYCLES  = 300;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_SUM,
      FRAME_BAD_HEADER,
      FRAME_BAD_ADDRESS,
      FRAME_NOISE
   } frame_kind_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   logic [sfr_pkg::BYTE_W-1:0]      req_rx_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   logic                            rsp_status;
   logic [sfr_pkg::BYTE_W-1:0]      rsp_frame_byte;
   logic [sfr_pkg::OUT_INDEX_W-1:0] rsp_byte_index;
   logic                            rsp_last;
   logic                            csr_wen     = 1'b0;
   logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [sfr_pkg::BYTE_W-1:0]      csr_wdata   = '0;

   int fail_count;
   int results_pending;
   int cycle_count = 0;

   // stimulus side copy of the registers, used to build frames
   logic [sfr_pkg::BYTE_W-1:0]    cfg_header = sfr_pkg::HEADER_RESET;
   logic [sfr_pkg::BYTE_W-1:0]    cfg_addr_a = sfr_pkg::ADDRESS_RESET;
   logic [sfr_pkg::BYTE_W-1:0]    cfg_addr_b = sfr_pkg::ADDRESS_RESET;
   logic [sfr_pkg::LEN_CFG_W-1:0] cfg_len    = sfr_pkg::FRAME_LEN_RESET;

   int   sender_idle_pct = 0;
   int   rsp_stall_pct   = 0;
   int   bytes_sent      = 0;
   logic hold_start      = 1'b0;
   logic hold_taken      = 1'b0;
   int   hold_left       = 0;

   serial_frame_receiver u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_last       (rsp_last),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   serial_frame_receiver_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_last        (rsp_last),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls: random per phase, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_start && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // offer one byte, with random idle cycles first, and wait for the transaction
   task automatic send_byte(input logic [sfr_pkg::BYTE_W-1:0] rx);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!(req_valid && !req_stall));
      bytes_sent++;
   endtask

   // register write once the block has drained every result
   task automatic write_reg(input logic [sfr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sfr_pkg::BYTE_W-1:0] data);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         sfr_pkg::CSR_HEADER:    cfg_header = data;
         sfr_pkg::CSR_ADDRESS_A: cfg_addr_a = data;
         sfr_pkg::CSR_ADDRESS_B: cfg_addr_b = data;
         sfr_pkg::CSR_FRAME_LEN: cfg_len    = data[sfr_pkg::LEN_CFG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_frame(input frame_kind_type kind);
      logic [sfr_pkg::BYTE_W-1:0] fb [0:sfr_pkg::MAX_FRAME_DEF-1];
      logic [sfr_pkg::BYTE_W-1:0] sum;
      int                         n;
      n = cfg_len;
      if (n < sfr_pkg::MIN_FRAME) n = sfr_pkg::MIN_FRAME;
      if (n > sfr_pkg::MAX_FRAME_DEF) n = sfr_pkg::MAX_FRAME_DEF;
      if (kind == FRAME_NOISE) begin
         repeat ($urandom_range(3, 1)) send_byte(sfr_pkg::BYTE_W'($urandom));
         return;
      end
      fb[0] = cfg_header;
      fb[1] = $urandom_range(1) ? cfg_addr_a : cfg_addr_b;
      for (int i = 2; i < n - 1; i++) fb[i] = sfr_pkg::BYTE_W'($urandom);
      sum = '0;
      for (int i = 0; i < n - 1; i++) sum = sum + fb[i];
      fb[n-1] = sum;
      case (kind)
         FRAME_BAD_SUM:    fb[n-1] = sum ^ sfr_pkg::BYTE_W'($urandom_range(255, 1));
         FRAME_BAD_HEADER: fb[0] = cfg_header ^ sfr_pkg::BYTE_W'($urandom_range(255, 1));
         FRAME_BAD_ADDRESS: begin
            do fb[1] = sfr_pkg::BYTE_W'($urandom);
            while (fb[1] == cfg_addr_a || fb[1] == cfg_addr_b);
         end
         default: ;
      endcase
      for (int i = 0; i < n; i++) send_byte(fb[i]);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct,
                            input logic [sfr_pkg::BYTE_W-1:0] len_value,
                            input logic with_hold);
      int start_count;
      int pick;
      write_reg(sfr_pkg::CSR_HEADER, sfr_pkg::BYTE_W'($urandom));
      write_reg(sfr_pkg::CSR_ADDRESS_A, sfr_pkg::BYTE_W'($urandom));
      write_reg(sfr_pkg::CSR_ADDRESS_B,
                $urandom_range(1) ? cfg_addr_a : sfr_pkg::BYTE_W'($urandom));
      write_reg(sfr_pkg::CSR_FRAME_LEN, len_value);
      sender_idle_pct = idle_pct;
      rsp_stall_pct  <= stall_pct;
      if (with_hold) hold_start <= 1'b1;
      start_count = bytes_sent;
      while (bytes_sent - start_count < PHASE_BYTES) begin
         pick = $urandom_range(99);
         if (pick < 70)      send_frame(FRAME_GOOD);
         else if (pick < 82) send_frame(FRAME_BAD_SUM);
         else if (pick < 88) send_frame(FRAME_BAD_HEADER);
         else if (pick < 94) send_frame(FRAME_BAD_ADDRESS);
         else                send_frame(FRAME_NOISE);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset header and addresses, shortest frames
      write_reg(sfr_pkg::CSR_FRAME_LEN, 8'd3);
      send_byte(8'hA5); send_byte(8'h01); send_byte(8'hA6);
      send_byte(8'hA5); send_byte(8'h01); send_byte(8'h00);
      // wrong header dropped, wrong address dropped and not retested as header
      send_byte(8'h00);
      send_byte(8'hA5); send_byte(8'h07);
      send_byte(8'hA5); send_byte(8'h01); send_byte(8'hA6);

      // register extremes
      write_reg(sfr_pkg::CSR_HEADER, 8'hFF);
      write_reg(sfr_pkg::CSR_ADDRESS_A, 8'h00);
      write_reg(sfr_pkg::CSR_ADDRESS_B, 8'hFF);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF);
      send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFE);

      // length below minimum acts as three
      write_reg(sfr_pkg::CSR_FRAME_LEN, 8'd0);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF);

      // length lowered mid-frame: next byte is the checksum of all held bytes
      write_reg(sfr_pkg::CSR_FRAME_LEN, 8'd5);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'h12);
      write_reg(sfr_pkg::CSR_FRAME_LEN, 8'd3);
      send_byte(8'h11);

      // header changed mid-frame aborts it
      write_reg(sfr_pkg::CSR_FRAME_LEN, 8'd6);
      send_byte(8'hFF); send_byte(8'h00);
      write_reg(sfr_pkg::CSR_HEADER, 8'h5A);
      send_byte(8'h33);

      // random frames across idling phases and register settings
      run_phase(0, 0, sfr_pkg::BYTE_W'($urandom_range(8, 3)), 1'b0);
      run_phase(50, 0, 8'd63, 1'b0);
      run_phase(0, 50, 8'hC1, 1'b0);
      run_phase(20, 20, sfr_pkg::BYTE_W'($urandom_range(12, 3)), 1'b0);
      run_phase(0, 0, 8'd8, 1'b1);

      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && results_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
sv/sfr_pkg.sv
sv/sfr_frame_parse.sv
sv/serial_frame_receiver.sv
sim/serial_frame_receiver_checker.sv
sim/serial_frame_receiver_tb.sv
